// ----- hdl/tsst_pkg.sv -----
package tsst_pkg;

	localparam int unsigned SRC_W = 32;
	localparam int unsigned CNT_W = 16;

	// Header lengths in 32-bit words; 20 bytes is five words
	localparam logic [3:0]       MIN_HDR_WORDS = 4'd5;
	localparam logic [7:0]       PROTO_TCP     = 8'd6;
	localparam logic [7:0]       SYN_MASK      = 8'h02;
	localparam logic [CNT_W-1:0] COUNT_MAX     = 16'hFFFF;
	localparam logic [CNT_W-1:0] THRESH_RESET  = 16'd20;

	typedef enum logic [2:0] {
		ST_BAD_IP,
		ST_NOT_TCP,
		ST_BAD_TCP,
		ST_NO_SYN,
		ST_NEW_SOURCE,
		ST_COUNTED,
		ST_SCAN_ALERT,
		ST_TABLE_FULL
	} status_t;

	// Lookup probe that walks the cell chain
	typedef struct packed {
		logic             vld;
		logic             hit;
		logic             bumped;
		logic [SRC_W-1:0] src;
		logic [CNT_W-1:0] cnt;
	} probe_t;

	// Append request broadcast to all cells
	typedef struct packed {
		logic             en;
		logic [SRC_W-1:0] src;
	} append_t;

endpackage

// ----- hdl/tsst_pkt_if.sv -----
interface tsst_pkt_if;
	logic        valid;
	logic        ready;
	logic [3:0]  ip_header_words;
	logic [7:0]  ip_protocol;
	logic [15:0] ip_total_length;
	logic [31:0] source_address;
	logic [3:0]  tcp_offset_words;
	logic [7:0]  tcp_flags;

	modport source (
		output valid, ip_header_words, ip_protocol, ip_total_length,
		       source_address, tcp_offset_words, tcp_flags,
		input  ready
	);
	modport sink (
		input  valid, ip_header_words, ip_protocol, ip_total_length,
		       source_address, tcp_offset_words, tcp_flags,
		output ready
	);
endinterface

// ----- hdl/tsst_verdict_if.sv -----
interface tsst_verdict_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] syn_tally;
	logic [7:0]  tracked_sources;
	logic [15:0] payload_length;

	modport source (
		output valid, status, syn_tally, tracked_sources, payload_length,
		input  ready
	);
	modport sink (
		input  valid, status, syn_tally, tracked_sources, payload_length,
		output ready
	);
endinterface

// ----- hdl/tsst_cfg_if.sv -----
interface tsst_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- hdl/tsst_cell.sv -----
module tsst_cell #(
	parameter int unsigned INDEX  = 0,
	parameter int unsigned FILL_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tsst_pkg::probe_t   probe_in,
	output tsst_pkg::probe_t   probe_out,
	input  logic [FILL_W-1:0]  fill,
	input  tsst_pkg::append_t  append
);

	localparam logic [FILL_W-1:0] MY_SLOT = FILL_W'(INDEX);

	logic [tsst_pkg::SRC_W-1:0] src_q;
	logic [tsst_pkg::CNT_W-1:0] cnt_q;
	logic [tsst_pkg::CNT_W-1:0] cnt_next;
	logic                       in_use;
	logic                       saturated;
	logic                       match;
	tsst_pkg::probe_t           probe_d;
	tsst_pkg::probe_t           probe_q;

	assign in_use    = MY_SLOT < fill;
	assign saturated = cnt_q == tsst_pkg::COUNT_MAX;
	assign cnt_next  = saturated ? cnt_q : cnt_q + 16'd1;
	assign match     = probe_in.vld && !probe_in.hit && in_use && (probe_in.src == src_q);

	always_comb begin
		probe_d = probe_in;
		if (match) begin
			probe_d.hit    = 1'b1;
			probe_d.bumped = !saturated;
			probe_d.cnt    = cnt_next;
		end
	end

	// Entry storage: written on append, bumped on a hit
	always_ff @(posedge clk) begin
		if (append.en && (fill == MY_SLOT)) begin
			src_q <= append.src;
			cnt_q <= 16'd1;
		end else if (match) begin
			cnt_q <= cnt_next;
		end
	end

	// Advance the probe one cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_d;
		end
	end

	assign probe_out = probe_q;

endmodule

// ----- hdl/tcp_syn_scan_tracker.sv -----
// An item that needs no table lookup passes through the pending register and then the output register;
// a SYN item's probe first walks the cell chain, one cell register per cell, before the pending register.
// One item at a time: a new item is accepted only once the previous result moves to the output register.
// Reset: asynchronous, active low; clears the fill count (table empty), sets the scan
// threshold to 20 and empties the pipeline. Table cells are not cleared.
module tcp_syn_scan_tracker #(
	parameter int unsigned TABLE_DEPTH = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	tsst_pkt_if.sink        pkt,
	tsst_verdict_if.source  verdict,
	tsst_cfg_if.sink        cfg
);

	localparam int unsigned FILL_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TABLE_DEPTH);

	// Configuration: one register, always ready
	logic [15:0] thresh_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= tsst_pkg::THRESH_RESET;
		end else if (cfg.valid) begin
			thresh_q <= cfg.data;
		end
	end

	// Control state
	logic              busy_q;
	logic              pend_q;
	logic              out_vld_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_next;

	// Payload registers
	tsst_pkg::status_t pend_status_q;
	logic [15:0]       pend_cnt_q;
	logic [7:0]        pend_ts_q;
	logic [15:0]       pend_pay_q;
	logic [15:0]       item_pay_q;
	tsst_pkg::status_t out_status_q;
	logic [15:0]       out_cnt_q;
	logic [7:0]        out_ts_q;
	logic [15:0]       out_pay_q;

	logic accept;
	logic move_out;

	assign pkt.ready = !busy_q;
	assign accept    = pkt.valid && !busy_q;
	assign move_out  = pend_q && (!out_vld_q || verdict.ready);

	// Header checks and payload length, all on the accepted item
	tsst_pkg::status_t pre_status;
	logic              need_search;
	logic [6:0]        hdr_bytes;
	logic [16:0]       pay_diff;
	logic [15:0]       pre_pay;

	assign hdr_bytes = {1'b0, pkt.ip_header_words, 2'b00}
		+ {1'b0, pkt.tcp_offset_words, 2'b00};
	assign pay_diff  = {1'b0, pkt.ip_total_length} - {10'd0, hdr_bytes};

	always_comb begin
		pre_status  = tsst_pkg::ST_NO_SYN;
		pre_pay     = 16'd0;
		need_search = 1'b0;
		if (pkt.ip_header_words < tsst_pkg::MIN_HDR_WORDS) begin
			pre_status = tsst_pkg::ST_BAD_IP;
		end else if (pkt.ip_protocol != tsst_pkg::PROTO_TCP) begin
			pre_status = tsst_pkg::ST_NOT_TCP;
		end else if (pkt.tcp_offset_words < tsst_pkg::MIN_HDR_WORDS) begin
			pre_status = tsst_pkg::ST_BAD_TCP;
		end else begin
			// Clamp at zero when the headers claim more than the total length
			pre_pay = pay_diff[16] ? 16'd0 : pay_diff[15:0];
			need_search = (pkt.tcp_flags & tsst_pkg::SYN_MASK) != 8'd0;
		end
	end

	// Cell chain: the probe enters cell 0 at the accept edge, passes one cell register per
	// cell and leaves the last cell with its hit flag and updated count.
	tsst_pkg::probe_t  probe_w [TABLE_DEPTH+1];
	tsst_pkg::append_t append;

	assign probe_w[0] = {accept && need_search, 1'b0, 1'b0, pkt.source_address,
		{tsst_pkg::CNT_W{1'b0}}};

	for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
		tsst_cell #(
			.INDEX  (gi),
			.FILL_W (FILL_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.probe_in  (probe_w[gi]),
			.probe_out (probe_w[gi+1]),
			.fill      (fill_q),
			.append    (append)
		);
	end

	// Resolve the probe at the end of the chain
	tsst_pkg::probe_t  probe_end;
	tsst_pkg::status_t end_status;
	logic [15:0]       end_cnt;
	logic              table_full;

	assign probe_end  = probe_w[TABLE_DEPTH];
	assign table_full = fill_q == FILL_FULL;

	always_comb begin
		append.en  = 1'b0;
		append.src = probe_end.src;
		fill_next  = fill_q;
		end_cnt    = 16'd0;
		end_status = tsst_pkg::ST_TABLE_FULL;
		if (probe_end.hit) begin
			end_cnt    = probe_end.cnt;
			// Alert only when this hit actually advanced the count onto the threshold
			end_status = (probe_end.bumped && (probe_end.cnt == thresh_q))
				? tsst_pkg::ST_SCAN_ALERT : tsst_pkg::ST_COUNTED;
		end else if (!table_full) begin
			append.en  = probe_end.vld;
			fill_next  = fill_q + 1'b1;
			end_cnt    = 16'd1;
			end_status = tsst_pkg::ST_NEW_SOURCE;
		end
	end

	// Entries in use, low 8 bits of the fill count
	logic [FILL_W+7:0] fill_ext_now;
	logic [FILL_W+7:0] fill_ext_next;

	assign fill_ext_now  = {8'd0, fill_q};
	assign fill_ext_next = {8'd0, fill_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			pend_q    <= 1'b0;
			out_vld_q <= 1'b0;
			fill_q    <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (move_out) begin
				busy_q <= 1'b0;
			end

			if (accept && !need_search) begin
				pend_q <= 1'b1;
			end else if (probe_end.vld) begin
				pend_q <= 1'b1;
				if (append.en) begin
					fill_q <= fill_next;
				end
			end else if (move_out) begin
				pend_q <= 1'b0;
			end

			if (move_out) begin
				out_vld_q <= 1'b1;
			end else if (verdict.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Hold the pending result and the output item
	always_ff @(posedge clk) begin
		if (accept) begin
			item_pay_q <= pre_pay;
			if (!need_search) begin
				pend_status_q <= pre_status;
				pend_cnt_q    <= 16'd0;
				pend_ts_q     <= fill_ext_now[7:0];
				pend_pay_q    <= pre_pay;
			end
		end else if (probe_end.vld) begin
			pend_status_q <= end_status;
			pend_cnt_q    <= end_cnt;
			pend_ts_q     <= fill_ext_next[7:0];
			pend_pay_q    <= item_pay_q;
		end

		if (move_out) begin
			out_status_q <= pend_status_q;
			out_cnt_q    <= pend_cnt_q;
			out_ts_q     <= pend_ts_q;
			out_pay_q    <= pend_pay_q;
		end
	end

	assign verdict.valid           = out_vld_q;
	assign verdict.status          = out_status_q;
	assign verdict.syn_tally       = out_cnt_q;
	assign verdict.tracked_sources = out_ts_q;
	assign verdict.payload_length  = out_pay_q;

endmodule
